### hw/rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared widths, codes and sequencer types of the triangle tangent space block.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

	localparam int IN_W   = 32;   // input field width
	localparam int OP_W   = 33;   // multiplier operand width (coordinate delta)
	localparam int P_W    = 66;   // full product width
	localparam int V_W    = 67;   // difference of two products
	localparam int M_W    = 31;   // magnitude width after range reduction
	localparam int SUM_W  = 64;   // sum of three squares
	localparam int LEN_W  = 32;   // vector length
	localparam int OUT_W  = 16;   // result field width
	localparam int IDX_W  = 4;    // product step counter

	localparam logic [SUM_W-1:0] SQ_TOP = {2'b01, {(SUM_W-2){1'b0}}};

	// Last product step of each pass
	localparam logic [IDX_W-1:0] LAST_FACE = 4'd13;
	localparam logic [IDX_W-1:0] LAST_NORM = 4'd5;
	localparam logic [IDX_W-1:0] LAST_SQ   = 4'd2;

	// Slots of the edge-product store
	localparam logic [2:0] SLOT_DET = 3'd0;
	localparam logic [2:0] SLOT_T0  = 3'd1;
	localparam logic [2:0] SLOT_B0  = 3'd4;

	// Corner position inside the current face
	localparam logic [1:0] CORNER_A = 2'd0;
	localparam logic [1:0] CORNER_B = 2'd1;
	localparam logic [1:0] CORNER_C = 2'd2;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PROD  = 8'b0000_0010,
		S_WAIT  = 8'b0000_0100,
		S_LOAD  = 8'b0000_1000,
		S_SHIFT = 8'b0001_0000,
		S_SQRT  = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		K_FACE = 3'b001,
		K_NORM = 3'b010,
		K_SQ   = 3'b100
	} kind_t;

	typedef enum logic [2:0] {
		T_TAN = 3'b001,
		T_BIN = 3'b010,
		T_NRM = 3'b100
	} tgt_t;

endpackage

`default_nettype wire

### hw/rtl/tts_mul.sv
// ----------------------------------------------------------------------------
// tts_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_mul (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [tts_pkg::OP_W-1:0]   a,
	input  logic signed [tts_pkg::OP_W-1:0]   b,
	output logic signed [tts_pkg::P_W-1:0]    prod_s1
);
	import tts_pkg::*;

	logic signed [P_W-1:0] prod;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tts_isqrt.sv
// ----------------------------------------------------------------------------
// tts_isqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tts_pkg::SUM_W-1:0]     x,
	output logic [tts_pkg::LEN_W-1:0]     root,
	output logic                          done
);
	import tts_pkg::*;

	logic [SUM_W-1:0] x_q;
	logic [SUM_W-1:0] res_q;
	logic [SUM_W-1:0] bit_q;
	logic [SUM_W-1:0] trial;
	logic             ge;
	logic             busy_q;
	logic             done_q;

	assign trial = res_q + bit_q;
	assign ge    = x_q >= trial;
	assign root  = res_q[LEN_W-1:0];
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (bit_q == SUM_W'(1)) && !start;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (bit_q == SUM_W'(1))) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			res_q <= '0;
			bit_q <= SQ_TOP;
		end else if (busy_q) begin
			if (ge) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tts_div.sv
// ----------------------------------------------------------------------------
// tts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_div #(
	parameter int QB = 16,
	parameter int NW = 46
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [NW-1:0]                 num,
	input  logic [tts_pkg::LEN_W-1:0]     den,
	output logic [QB-1:0]                 quo,
	output logic                          done
);
	import tts_pkg::*;

	localparam int CW = $clog2(QB + 1);

	logic [LEN_W-1:0] rem_q;
	logic [QB-1:0]    lo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W:0]   r2;
	logic [LEN_W:0]   diff;
	logic             ge;

	assign r2   = {rem_q, lo_q[QB-1]};
	assign diff = r2 - {1'b0, den};
	assign ge   = r2 >= {1'b0, den};
	assign quo  = lo_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1)) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= LEN_W'(num >> QB);
			lo_q  <= num[QB-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[LEN_W-1:0] : r2[LEN_W-1:0];
			lo_q  <= {lo_q[QB-2:0], ge};
		end
	end

endmodule

`default_nettype wire

### hw/rtl/triangle_tangent_space_top.sv
// ----------------------------------------------------------------------------
// triangle_tangent_space_top
// Per-face tangent, binormal and normal from a triangle-list vertex stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one vertex item per handshake (position and
//   texture coordinates, signed Q16.16). Vertices group into faces of three
//   in arrival order. The first two corners of a face are stored at once and
//   give no result; the third starts the face computation, and exactly one
//   result item follows with the three unit vectors (OUT_FRAC_BITS fraction
//   bits) and a degenerate flag.
//   Corner items are stored as they are taken. Before the square root, the
//   tangent and binormal magnitudes are shifted right one bit at a time, by
//   up to 34 bits each, until they fit in 31 bits; the normal needs none.
//   A zero determinant skips the vector passes and goes straight to the
//   result. Each vector takes a 32-step square root and three serial
//   divisions; one shared multiplier forms all edge products and squares.
//   in_ready is low while a face is in work. A finished result sits in the
//   output register; while the receiver stalls, the next face's corners are
//   still taken, and the next face waits for the register to free up.
//   Reset clears the corner counter and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_space_top #(
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [tts_pkg::IN_W-1:0]   pos_x,
	input  logic signed [tts_pkg::IN_W-1:0]   pos_y,
	input  logic signed [tts_pkg::IN_W-1:0]   pos_z,
	input  logic signed [tts_pkg::IN_W-1:0]   tex_u,
	input  logic signed [tts_pkg::IN_W-1:0]   tex_v,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tts_pkg::OUT_W-1:0]  tangent_x,
	output logic signed [tts_pkg::OUT_W-1:0]  tangent_y,
	output logic signed [tts_pkg::OUT_W-1:0]  tangent_z,
	output logic signed [tts_pkg::OUT_W-1:0]  binormal_x,
	output logic signed [tts_pkg::OUT_W-1:0]  binormal_y,
	output logic signed [tts_pkg::OUT_W-1:0]  binormal_z,
	output logic signed [tts_pkg::OUT_W-1:0]  normal_x,
	output logic signed [tts_pkg::OUT_W-1:0]  normal_y,
	output logic signed [tts_pkg::OUT_W-1:0]  normal_z,
	output logic                              degenerate
);
	import tts_pkg::*;

	// Quotient bits, signed unit-vector width, divider numerator width
	localparam int QB = OUT_FRAC_BITS + 2;
	localparam int QW = OUT_FRAC_BITS + 3;
	localparam int NW = OUT_FRAC_BITS + M_W + 1;

	function automatic logic [OUT_W-1:0] to_out(input logic signed [QW-1:0] v);
		logic signed [OP_W:0] w;
		w = (OP_W + 1)'(v);
		return w[OUT_W-1:0];
	endfunction

	// Control state
	state_t            state_q, state_d;
	kind_t             kind_q, kind_d;
	tgt_t              tgt_q, tgt_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [1:0]        comp_q, comp_d;
	logic [1:0]        cidx_q;
	logic              deg_q;
	logic              out_valid_q;
	logic              p_vld_s1;
	logic [IDX_W-1:0]  p_idx_s1;
	logic              sqrt_go_q;
	logic              div_go_q;

	// Strobes from the sequencer
	logic accept, start_face, issue, set_deg, clr_deg;
	logic ld_m, shift_m, clr_sum, st_div, ld_out, sqrt_go, div_go;

	// Datapath storage
	logic signed [IN_W-1:0]  c1_q [5];
	logic signed [IN_W-1:0]  c2_q [5];
	logic signed [IN_W-1:0]  c3_q [5];
	logic signed [P_W-1:0]   acc_q;
	logic signed [V_W-1:0]   vr_q [7];
	logic [V_W-1:0]          m_q [3];
	logic                    sg_q [3];
	logic [SUM_W-1:0]        sum_q;
	logic signed [QW-1:0]    t_q [3];
	logic signed [QW-1:0]    b_q [3];
	logic signed [QW-1:0]    n_q [3];

	// Deltas of the face
	logic signed [OP_W-1:0]  e1 [3];
	logic signed [OP_W-1:0]  e2 [3];
	logic signed [OP_W-1:0]  du1, dv1, du2, dv2;

	// Shared units
	logic signed [OP_W-1:0]  mul_a, mul_b;
	logic signed [P_W-1:0]   prod_s1;
	logic [LEN_W-1:0]        sq_root;
	logic                    sq_done;
	logic [NW-1:0]           dv_num;
	logic [QB-1:0]           dv_quo;
	logic                    dv_done;

	logic [IDX_W-1:0]        last_idx;
	logic [2:0]              pair;
	logic                    second;
	logic [1:0]              lane;
	logic                    m_high;
	logic                    det_neg;
	logic signed [QW-1:0]    qv;
	logic signed [QW-1:0]    qs;
	logic [2:0]              wslot;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign start_face = accept && (cidx_q == CORNER_C);
	assign out_valid  = out_valid_q;
	assign det_neg    = vr_q[SLOT_DET][V_W-1];
	assign m_high     = |((m_q[0] | m_q[1] | m_q[2]) >> M_W);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1[i] = OP_W'(c2_q[i]) - OP_W'(c1_q[i]);
			e2[i] = OP_W'(c3_q[i]) - OP_W'(c1_q[i]);
		end
		du1 = OP_W'(c2_q[3]) - OP_W'(c1_q[3]);
		dv1 = OP_W'(c2_q[4]) - OP_W'(c1_q[4]);
		du2 = OP_W'(c3_q[3]) - OP_W'(c1_q[3]);
		dv2 = OP_W'(c3_q[4]) - OP_W'(c1_q[4]);
	end

	// Operand select: pairs of products, first term then subtracted term; squares in the square pass
	always_comb begin
		pair   = idx_q[IDX_W-1:1];
		second = idx_q[0];
		mul_a  = '0;
		mul_b  = '0;
		lane   = 2'd0;
		case (kind_q)
			K_FACE: begin
				case (pair)
					3'd0: begin
						mul_a = second ? du2 : du1;
						mul_b = second ? dv1 : dv2;
					end
					3'd1, 3'd2, 3'd3: begin
						lane  = 2'(pair - 3'd1);
						mul_a = second ? dv1 : dv2;
						mul_b = second ? e2[lane] : e1[lane];
					end
					default: begin
						lane  = 2'(pair - 3'd4);
						mul_a = second ? du2 : du1;
						mul_b = second ? e1[lane] : e2[lane];
					end
				endcase
			end
			K_NORM: begin
				case (pair)
					3'd0: begin
						mul_a = OP_W'(second ? t_q[2] : t_q[1]);
						mul_b = OP_W'(second ? b_q[1] : b_q[2]);
					end
					3'd1: begin
						mul_a = OP_W'(second ? t_q[0] : t_q[2]);
						mul_b = OP_W'(second ? b_q[2] : b_q[0]);
					end
					default: begin
						mul_a = OP_W'(second ? t_q[1] : t_q[0]);
						mul_b = OP_W'(second ? b_q[0] : b_q[1]);
					end
				endcase
			end
			default: begin
				mul_a = {2'b00, m_q[idx_q[1:0]][M_W-1:0]};
				mul_b = {2'b00, m_q[idx_q[1:0]][M_W-1:0]};
			end
		endcase
	end

	always_comb begin
		case (kind_q)
			K_FACE:  last_idx = LAST_FACE;
			K_NORM:  last_idx = LAST_NORM;
			default: last_idx = LAST_SQ;
		endcase
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		tgt_d   = tgt_q;
		idx_d   = idx_q;
		comp_d  = comp_q;
		issue   = 1'b0;
		set_deg = 1'b0;
		clr_deg = 1'b0;
		ld_m    = 1'b0;
		shift_m = 1'b0;
		clr_sum = 1'b0;
		st_div  = 1'b0;
		ld_out  = 1'b0;
		sqrt_go = 1'b0;
		div_go  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start_face) begin
					state_d = S_PROD;
					kind_d  = K_FACE;
					idx_d   = '0;
					clr_deg = 1'b1;
				end
			end
			S_PROD: begin
				issue = 1'b1;
				if (idx_q == last_idx) begin
					state_d = S_WAIT;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			S_WAIT: begin
				case (kind_q)
					K_FACE: begin
						if (vr_q[SLOT_DET] == '0) begin
							set_deg = 1'b1;
							state_d = S_FIN;
						end else begin
							tgt_d   = T_TAN;
							state_d = S_LOAD;
						end
					end
					K_NORM: begin
						tgt_d   = T_NRM;
						state_d = S_LOAD;
					end
					default: begin
						sqrt_go = 1'b1;
						state_d = S_SQRT;
					end
				endcase
			end
			S_LOAD: begin
				ld_m    = 1'b1;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				if (m_high) begin
					shift_m = 1'b1;
				end else begin
					clr_sum = 1'b1;
					kind_d  = K_SQ;
					idx_d   = '0;
					state_d = S_PROD;
				end
			end
			S_SQRT: begin
				if (sq_done) begin
					if (sq_root == '0) begin
						set_deg = 1'b1;
						state_d = S_FIN;
					end else begin
						comp_d  = 2'd0;
						div_go  = 1'b1;
						state_d = S_DIV;
					end
				end
			end
			S_DIV: begin
				if (dv_done) begin
					st_div = 1'b1;
					if (comp_q == 2'd2) begin
						case (tgt_q)
							T_TAN: begin
								tgt_d   = T_BIN;
								state_d = S_LOAD;
							end
							T_BIN: begin
								kind_d  = K_NORM;
								idx_d   = '0;
								state_d = S_PROD;
							end
							default: begin
								state_d = S_FIN;
							end
						endcase
					end else begin
						comp_d = comp_q + 2'd1;
						div_go = 1'b1;
					end
				end
			end
			S_FIN: begin
				// Hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					ld_out  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= K_FACE;
			tgt_q       <= T_TAN;
			idx_q       <= '0;
			comp_q      <= 2'd0;
			cidx_q      <= CORNER_A;
			deg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			p_vld_s1    <= 1'b0;
			sqrt_go_q   <= 1'b0;
			div_go_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			kind_q    <= kind_d;
			tgt_q     <= tgt_d;
			idx_q     <= idx_d;
			comp_q    <= comp_d;
			p_vld_s1  <= issue;
			sqrt_go_q <= sqrt_go;
			div_go_q  <= div_go;
			if (accept) begin
				case (cidx_q)
					CORNER_B: cidx_q <= CORNER_C;
					CORNER_C: cidx_q <= CORNER_A;
					default:  cidx_q <= CORNER_B;
				endcase
			end
			if (clr_deg) begin
				deg_q <= 1'b0;
			end else if (set_deg) begin
				deg_q <= 1'b1;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Unit vector component from the divider, with sign restored
	always_comb begin
		qv = QW'(dv_quo);
		if (sg_q[comp_q] ^ ((tgt_q != T_NRM) && det_neg)) begin
			qs = -qv;
		end else begin
			qs = qv;
		end
	end

	assign dv_num = (NW'(m_q[comp_q][M_W-1:0]) << OUT_FRAC_BITS) + NW'(sq_root[LEN_W-1:1]);

	always_comb begin
		if (kind_q == K_NORM) begin
			wslot = 3'(p_idx_s1[IDX_W-1:1]) + SLOT_T0;
		end else begin
			wslot = 3'(p_idx_s1[IDX_W-1:1]);
		end
	end

	always_ff @(posedge clk) begin
		p_idx_s1 <= idx_q;
		if (accept) begin
			case (cidx_q)
				CORNER_B: c2_q <= '{pos_x, pos_y, pos_z, tex_u, tex_v};
				CORNER_C: c3_q <= '{pos_x, pos_y, pos_z, tex_u, tex_v};
				default:  c1_q <= '{pos_x, pos_y, pos_z, tex_u, tex_v};
			endcase
		end
		// Accumulate each product in the cycle after the multiplier registers it
		if (clr_sum) begin
			sum_q <= '0;
		end else if (p_vld_s1) begin
			if (kind_q == K_SQ) begin
				sum_q <= sum_q + prod_s1[SUM_W-1:0];
			end else if (!p_idx_s1[0]) begin
				acc_q <= prod_s1;
			end else begin
				vr_q[wslot] <= V_W'(acc_q) - V_W'(prod_s1);
			end
		end
		if (ld_m) begin
			for (int i = 0; i < 3; i++) begin
				if (tgt_q == T_BIN) begin
					sg_q[i] <= vr_q[SLOT_B0 + 3'(i)][V_W-1];
					m_q[i]  <= vr_q[SLOT_B0 + 3'(i)][V_W-1] ?
						V_W'(-vr_q[SLOT_B0 + 3'(i)]) : V_W'(vr_q[SLOT_B0 + 3'(i)]);
				end else begin
					sg_q[i] <= vr_q[SLOT_T0 + 3'(i)][V_W-1];
					m_q[i]  <= vr_q[SLOT_T0 + 3'(i)][V_W-1] ?
						V_W'(-vr_q[SLOT_T0 + 3'(i)]) : V_W'(vr_q[SLOT_T0 + 3'(i)]);
				end
			end
		end else if (shift_m) begin
			for (int i = 0; i < 3; i++) begin
				m_q[i] <= m_q[i] >> 1;
			end
		end
		if (st_div) begin
			case (tgt_q)
				T_TAN:   t_q[comp_q] <= qs;
				T_BIN:   b_q[comp_q] <= qs;
				default: n_q[comp_q] <= qs;
			endcase
		end
		// Drop the vectors of a degenerate face
		if (ld_out) begin
			degenerate <= deg_q;
			tangent_x  <= deg_q ? '0 : to_out(t_q[0]);
			tangent_y  <= deg_q ? '0 : to_out(t_q[1]);
			tangent_z  <= deg_q ? '0 : to_out(t_q[2]);
			binormal_x <= deg_q ? '0 : to_out(b_q[0]);
			binormal_y <= deg_q ? '0 : to_out(b_q[1]);
			binormal_z <= deg_q ? '0 : to_out(b_q[2]);
			normal_x   <= deg_q ? '0 : to_out(n_q[0]);
			normal_y   <= deg_q ? '0 : to_out(n_q[1]);
			normal_z   <= deg_q ? '0 : to_out(n_q[2]);
		end
	end

	tts_mul u_mul (
		.clk     (clk),
		.en      (issue),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	tts_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_go_q),
		.x      (sum_q),
		.root   (sq_root),
		.done   (sq_done)
	);

	tts_div #(
		.QB (QB),
		.NW (NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (dv_num),
		.den    (sq_root),
		.quo    (dv_quo),
		.done   (dv_done)
	);

endmodule

`default_nettype wire

### hw/rtl/tts_chk.sv
// ----------------------------------------------------------------------------
// tts_chk
// Port-level checks of the triangle tangent space block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_ready,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [tts_pkg::OUT_W-1:0]  tangent_x,
	input  logic signed [tts_pkg::OUT_W-1:0]  tangent_y,
	input  logic signed [tts_pkg::OUT_W-1:0]  tangent_z,
	input  logic signed [tts_pkg::OUT_W-1:0]  binormal_x,
	input  logic signed [tts_pkg::OUT_W-1:0]  binormal_y,
	input  logic signed [tts_pkg::OUT_W-1:0]  binormal_z,
	input  logic signed [tts_pkg::OUT_W-1:0]  normal_x,
	input  logic signed [tts_pkg::OUT_W-1:0]  normal_y,
	input  logic signed [tts_pkg::OUT_W-1:0]  normal_z,
	input  logic                              degenerate
);
	import tts_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(tangent_x) && $stable(binormal_y)
			&& $stable(normal_z) && $stable(degenerate))
		else $error("stalled result item changed");

	// A new result only follows a busy cycle of the face sequencer
	a_busy_before: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without face work");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tangent_x == 0 && tangent_y == 0
			&& tangent_z == 0 && binormal_x == 0 && binormal_y == 0
			&& binormal_z == 0 && normal_x == 0 && normal_y == 0 && normal_z == 0)
		else $error("degenerate item carries nonzero vectors");

endmodule

bind triangle_tangent_space_top tts_chk u_tts_chk (.*);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-face tangent space block: a directed table
// of vertices, then random faces, each result checked against a local face
// predictor while both channels idle and stall in phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int OFB = 14;
	localparam logic signed [15:0] ONE = 16'sd16384;

	typedef struct packed {
		logic signed [31:0] px, py, pz, tu, tv;
	} vertex_t;

	typedef struct packed {
		logic signed [15:0] tx, ty, tz, bx, by, bz, nx, ny, nz;
		logic               dg;
	} frame_t;

	// Directed row: a vertex, and for face-closing rows an optional typed answer
	typedef struct {
		vertex_t v;
		bit      typed;
		frame_t  f;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
	logic in_ready, out_valid, degenerate;
	logic signed [15:0] tangent_x, tangent_y, tangent_z;
	logic signed [15:0] binormal_x, binormal_y, binormal_z;
	logic signed [15:0] normal_x, normal_y, normal_z;

	triangle_tangent_space_top #(.OUT_FRAC_BITS(OFB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
		.out_valid(out_valid), .out_ready(out_ready),
		.tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
		.binormal_x(binormal_x), .binormal_y(binormal_y), .binormal_z(binormal_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate)
	);

	always #6 clk = ~clk;

	// Idle phase codes
	typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} phase_t;
	phase_t phase = PH_NONE;

	frame_t  frames_due[$];
	vertex_t held_a, held_b;
	int      corner_no = 0;
	int      errors = 0;
	bit      hold_off = 1'b0;
	bit      hold_req = 1'b0;

	// ------------------------------------------------------------------
	// Face predictor
	// ------------------------------------------------------------------
	// Normalize a vector of three signed components (up to 67 bits) to Q1.OFB; 0 if zero length
	function automatic bit unit_vec(input logic signed [67:0] v [3],
			output logic signed [15:0] r [3]);
		logic [67:0] mag [3];
		logic [67:0] all;
		logic [63:0] m [3];
		logic [63:0] sum, len, rem, bitv, q;
		int s;
		all = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? -v[i] : v[i];
			all |= mag[i];
		end
		s = 0;
		while ((all >> s) >= 68'h8000_0000) s++;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			m[i] = 64'((mag[i] >> s) & 68'h7FFF_FFFF);
			sum += m[i] * m[i];
		end
		// integer square root, digit by digit
		len = '0;
		rem = sum;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > rem) bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= len + bitv) begin
				rem -= len + bitv;
				len = (len >> 1) + bitv;
			end else begin
				len >>= 1;
			end
			bitv >>= 2;
		end
		if (len == 0) return 1'b0;
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << OFB) + len / 2) / len;
			r[i] = v[i] < 0 ? -16'(q) : 16'(q);
		end
		return 1'b1;
	endfunction

	function automatic frame_t face_frame(input vertex_t a, input vertex_t b, input vertex_t c);
		logic signed [32:0] e1 [3], e2 [3];
		logic signed [32:0] du1, dv1, du2, dv2;
		logic signed [67:0] det;
		logic signed [67:0] tv [3], bv [3], nv [3];
		logic signed [15:0] t [3], bn [3], n [3];
		frame_t f;
		bit ok;
		e1[0] = 33'(b.px) - 33'(a.px); e2[0] = 33'(c.px) - 33'(a.px);
		e1[1] = 33'(b.py) - 33'(a.py); e2[1] = 33'(c.py) - 33'(a.py);
		e1[2] = 33'(b.pz) - 33'(a.pz); e2[2] = 33'(c.pz) - 33'(a.pz);
		du1 = 33'(b.tu) - 33'(a.tu); dv1 = 33'(b.tv) - 33'(a.tv);
		du2 = 33'(c.tu) - 33'(a.tu); dv2 = 33'(c.tv) - 33'(a.tv);
		det = 68'(du1) * 68'(dv2) - 68'(du2) * 68'(dv1);
		for (int i = 0; i < 3; i++) begin
			tv[i] = 68'(dv2) * 68'(e1[i]) - 68'(dv1) * 68'(e2[i]);
			bv[i] = 68'(du1) * 68'(e2[i]) - 68'(du2) * 68'(e1[i]);
		end
		ok = det != 0;
		if (ok) ok = unit_vec(tv, t);
		if (ok) ok = unit_vec(bv, bn);
		if (ok) begin
			if (det < 0) begin
				for (int i = 0; i < 3; i++) begin
					t[i] = -t[i];
					bn[i] = -bn[i];
				end
			end
			nv[0] = 68'(t[1]) * 68'(bn[2]) - 68'(t[2]) * 68'(bn[1]);
			nv[1] = 68'(t[2]) * 68'(bn[0]) - 68'(t[0]) * 68'(bn[2]);
			nv[2] = 68'(t[0]) * 68'(bn[1]) - 68'(t[1]) * 68'(bn[0]);
			ok = unit_vec(nv, n);
		end
		if (!ok) return '{dg: 1'b1, default: '0};
		f = '{t[0], t[1], t[2], bn[0], bn[1], bn[2], n[0], n[1], n[2], 1'b0};
		return f;
	endfunction

	// Track the corner count and queue a frame on every third accepted vertex
	function automatic void vertex_taken(input vertex_t v, input bit typed,
			input frame_t want);
		frame_t f;
		if (corner_no == 0) begin
			held_a = v;
			corner_no = 1;
		end else if (corner_no == 1) begin
			held_b = v;
			corner_no = 2;
		end else begin
			f = face_frame(held_a, held_b, v);
			if (typed && f !== want)
				$error("predictor disagrees with typed row: %h vs %h", f, want);
			frames_due.push_back(typed ? want : f);
			corner_no = 0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------
	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			2: return 32'($signed($urandom_range(0, 65535)) - 32768);
			3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return 32'($signed($urandom_range(0, 20)) - 10) <<< $urandom_range(0, 24);
		endcase
	endfunction

	function automatic vertex_t rnd_vertex();
		return '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
	endfunction

	// Offer one vertex and hold it until taken, with sender idle gaps first.
	// Valid stays up after the handshake; the caller drops it when it pauses.
	task automatic send_vertex(input vertex_t v, input bit typed, input frame_t want);
		int gap;
		gap = 0;
		if (phase == PH_SEND && $urandom_range(0, 99) < 79) gap = $urandom_range(1, 20);
		if (phase == PH_BOTH && $urandom_range(0, 99) < 8) gap = $urandom_range(1, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		{pos_x, pos_y, pos_z, tex_u, tex_v} <= v;
		do @(posedge clk); while (!in_ready);
		vertex_taken(v, typed, want);
		@(negedge clk);
	endtask

	// Receiver: random stalls by phase, or a long hold-off when asked
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_off = 1'b1;
				out_ready <= 1'b0;
				for (n = 0; n < 3000; n++) @(negedge clk);
				hold_off = 1'b0;
				hold_req = 1'b0;
			end
			case (phase)
				PH_RECV: out_ready <= $urandom_range(0, 99) >= 79;
				PH_BOTH: out_ready <= $urandom_range(0, 99) >= 8;
				default: out_ready <= 1'b1;
			endcase
		end
	end

	// Compare each result item with the oldest expected frame
	always @(posedge clk) begin
		frame_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z,
				normal_x, normal_y, normal_z, degenerate};
			if (frames_due.size() == 0) begin
				$error("result item with no face pending");
				errors++;
			end else begin
				want = frames_due.pop_front();
				if (got.tx !== want.tx) begin $error("tangent_x exp %0d got %0d", want.tx, got.tx); errors++; end
				if (got.ty !== want.ty) begin $error("tangent_y exp %0d got %0d", want.ty, got.ty); errors++; end
				if (got.tz !== want.tz) begin $error("tangent_z exp %0d got %0d", want.tz, got.tz); errors++; end
				if (got.bx !== want.bx) begin $error("binormal_x exp %0d got %0d", want.bx, got.bx); errors++; end
				if (got.by !== want.by) begin $error("binormal_y exp %0d got %0d", want.by, got.by); errors++; end
				if (got.bz !== want.bz) begin $error("binormal_z exp %0d got %0d", want.bz, got.bz); errors++; end
				if (got.nx !== want.nx) begin $error("normal_x exp %0d got %0d", want.nx, got.nx); errors++; end
				if (got.ny !== want.ny) begin $error("normal_y exp %0d got %0d", want.ny, got.ny); errors++; end
				if (got.nz !== want.nz) begin $error("normal_z exp %0d got %0d", want.nz, got.nz); errors++; end
				if (got.dg !== want.dg) begin $error("degenerate exp %0d got %0d", want.dg, got.dg); errors++; end
			end
		end
	end

	// Hard limit: ~600 faces, stretched by stalls, with room to spare
	initial begin
		#80ms;
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic vertex_t vx(input int x, input int y, input int z,
			input int u, input int v);
		return '{32'(x) <<< 16, 32'(y) <<< 16, 32'(z) <<< 16, 32'(u) <<< 16, 32'(v) <<< 16};
	endfunction

	initial begin
		row_t   rows [$];
		frame_t none;
		frame_t axis;
		frame_t flat;
		vertex_t v;
		int n;
		none = '0;
		axis = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1'b0};
		flat = '{dg: 1'b1, default: '0};

		// Axis-aligned face: tangent x, binormal y, normal z
		rows.push_back('{vx(0, 0, 0, 0, 0), 0, none});
		rows.push_back('{vx(1, 0, 0, 1, 0), 0, none});
		rows.push_back('{vx(0, 1, 0, 0, 1), 1, axis});
		// Zero texture determinant
		rows.push_back('{vx(0, 0, 0, 5, 5), 0, none});
		rows.push_back('{vx(1, 0, 0, 5, 5), 0, none});
		rows.push_back('{vx(0, 1, 0, 5, 5), 1, flat});
		// Collapsed positions: zero tangent length
		rows.push_back('{vx(3, 3, 3, 0, 0), 0, none});
		rows.push_back('{vx(3, 3, 3, 1, 0), 0, none});
		rows.push_back('{vx(3, 3, 3, 0, 1), 1, flat});
		// Mirrored texture: negative determinant
		rows.push_back('{vx(0, 0, 0, 0, 0), 0, none});
		rows.push_back('{vx(1, 0, 0, 0, 1), 0, none});
		rows.push_back('{vx(0, 1, 0, 1, 0), 0, none});
		// Parallel tangent and binormal: zero normal
		rows.push_back('{vx(0, 0, 0, 0, 0), 0, none});
		rows.push_back('{vx(1, 0, 0, 1, 1), 0, none});
		rows.push_back('{vx(2, 0, 0, 1, -1), 0, none});
		// Extremes of every field, forcing range reduction
		rows.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000}, 0, none});
		rows.push_back('{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000}, 0, none});
		rows.push_back('{'{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF}, 0, none});
		// Tiny fractional steps
		rows.push_back('{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 0, none});
		rows.push_back('{'{32'd1, 32'd0, 32'd1, 32'd1, 32'd0}, 0, none});
		rows.push_back('{'{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1}, 0, none});

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) send_vertex(rows[i].v, rows[i].typed, rows[i].f);

		// Random faces over the idle phases; after each phase let the pipe drain
		for (int p = 0; p < 4; p++) begin
			phase = phase_t'(p);
			for (n = 0; n < 420; n++) begin
				v = rnd_vertex();
				// sometimes reuse the first corner's u coordinate in the third corner
				if (corner_no == 2 && $urandom_range(0, 9) == 0) v.tu = held_a.tu;
				send_vertex(v, 1'b0, none);
			end
			in_valid <= 1'b0;
			while (frames_due.size() != 0) @(negedge clk);
		end

		// Long receiver hold-off while vertices keep coming, to back up the input
		phase = PH_NONE;
		hold_req = 1'b1;
		@(negedge clk);
		for (n = 0; n < 30; n++) send_vertex(rnd_vertex(), 1'b0, none);
		while (corner_no != 0) send_vertex(rnd_vertex(), 1'b0, none);
		in_valid <= 1'b0;

		while (frames_due.size() != 0 || hold_off) @(negedge clk);
		repeat (400) @(negedge clk);
		if (errors == 0 && frames_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
hw/rtl/tts_pkg.sv
hw/rtl/tts_mul.sv
hw/rtl/tts_isqrt.sv
hw/rtl/tts_div.sv
hw/rtl/triangle_tangent_space_top.sv
hw/rtl/tts_chk.sv
tb/sv/tb.sv
